FILE: design/trc_pkg.sv
// Shared types, constants and helper functions for the touch report classifier.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package trc_pkg;

    localparam int NUM_FINGERS = 2;

    localparam int COORD_W = 12;
    localparam int PRESS_W = 8;
    localparam int WIDTH_W = 4;
    localparam int KEY_W   = 3;
    localparam int RAW_W   = 40;

    localparam int IRQ_ABS_BIT = 2;
    localparam int F0_BIT      = 0;
    localparam int F1_BIT      = 2;

    // Frame queue between classifier and event sequencer
    localparam int QDEPTH = 2;
    localparam int QAW    = 1;
    localparam int QCNT_W = 2;
    localparam int NEV_W  = 2;

    // Configuration register map
    localparam int                  CFG_IDX_W         = 1;
    localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_MAX_Y = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_MIN_Y     = 1'b1;
    localparam logic [COORD_W-1:0]  DISPLAY_MAX_Y_RST = 12'd1728;
    localparam logic [COORD_W-1:0]  KEY_MIN_Y_RST     = 12'd1805;

    // Key zone bounds on X (exclusive)
    localparam logic [COORD_W-1:0] MENU_LO   = 12'd35;
    localparam logic [COORD_W-1:0] MENU_HI   = 12'd245;
    localparam logic [COORD_W-1:0] HOME_LO   = 12'd287;
    localparam logic [COORD_W-1:0] HOME_HI   = 12'd497;
    localparam logic [COORD_W-1:0] BACK_LO   = 12'd539;
    localparam logic [COORD_W-1:0] BACK_HI   = 12'd749;
    localparam logic [COORD_W-1:0] SEARCH_LO = 12'd791;
    localparam logic [COORD_W-1:0] SEARCH_HI = 12'd1001;

    localparam logic [KEY_W-1:0] KEY_NONE   = 3'd0;
    localparam logic [KEY_W-1:0] BTN_MENU   = 3'd1;
    localparam logic [KEY_W-1:0] BTN_HOME   = 3'd2;
    localparam logic [KEY_W-1:0] BTN_BACK   = 3'd3;
    localparam logic [KEY_W-1:0] BTN_SEARCH = 3'd4;

    typedef enum logic [1:0] {
        EV_POINT   = 2'd0,
        EV_PRESS   = 2'd1,
        EV_RELEASE = 2'd2,
        EV_END     = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        MODE_NONE   = 3'b001,
        MODE_KEY    = 3'b010,
        MODE_SCREEN = 3'b100
    } mode_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [PRESS_W-1:0] p;
        logic [WIDTH_W-1:0] w;
    } finger_t;

    typedef struct packed {
        kind_t              kind;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [PRESS_W-1:0] p;
        logic [WIDTH_W-1:0] w;
        logic [KEY_W-1:0]   key;
    } event_t;

    // Up to two events of one frame; the frame end is implied
    typedef struct packed {
        event_t             ev0;
        event_t             ev1;
        logic [NEV_W-1:0]   n_ev;
    } frame_t;

    function automatic finger_t decode_finger(input logic [RAW_W-1:0] raw);
        finger_t    f;
        logic [3:0] hi;
        logic [3:0] lo;
        hi  = raw[31:28];
        lo  = raw[27:24];
        f.x = {raw[7:0], raw[19:16]};
        f.y = {raw[15:8], raw[23:20]};
        f.w = (hi > lo) ? hi : lo;
        f.p = raw[39:32];
        return f;
    endfunction

    function automatic logic [KEY_W-1:0] zone_key(input logic [COORD_W-1:0] x);
        logic [KEY_W-1:0] k;
        if (x > MENU_LO && x < MENU_HI)
            k = BTN_MENU;
        else if (x > HOME_LO && x < HOME_HI)
            k = BTN_HOME;
        else if (x > BACK_LO && x < BACK_HI)
            k = BTN_BACK;
        else if (x > SEARCH_LO && x < SEARCH_HI)
            k = BTN_SEARCH;
        else
            k = KEY_NONE;
        return k;
    endfunction

endpackage

`default_nettype wire

FILE: design/trc_front.sv
// Front end: configuration registers, frame classification and mode state.
// Depends on trc_pkg; pushes one frame record per accepted frame into trc_queue.
`timescale 1ns / 1ps
`default_nettype none

module trc_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [trc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [trc_pkg::COORD_W-1:0]    cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [7:0]                     irq_status,
    input  wire logic [7:0]                     finger_state,
    input  wire logic [trc_pkg::RAW_W-1:0]      finger0_bytes,
    input  wire logic [trc_pkg::RAW_W-1:0]      finger1_bytes,
    input  wire logic                           q_full,
    output logic                                push,
    output trc_pkg::frame_t                     push_frame
);
    import trc_pkg::*;

    logic [COORD_W-1:0] display_max_y_reg;
    logic [COORD_W-1:0] key_min_y_reg;
    mode_t              prior_mode_reg;
    mode_t              prior_mode_next;
    logic [KEY_W-1:0]   held_key_reg;
    logic               first_down_reg;

    finger_t          f0;
    finger_t          f1;
    logic             abs_data;
    logic             p0;
    logic             p1;
    logic             single;
    logic             single_screen;
    logic             y0_disp;
    logic             y1_disp;
    logic             y0_key;
    logic [KEY_W-1:0] key0;
    logic             a_v;
    logic             b_v;
    logic             press;
    event_t           a_ev;
    event_t           point0;
    event_t           point1;
    event_t           release_ev;
    event_t           press_ev;
    logic             accept;

    assign f0       = decode_finger(finger0_bytes);
    assign f1       = decode_finger(finger1_bytes);
    assign abs_data = irq_status[IRQ_ABS_BIT];
    assign p0       = finger_state[F0_BIT];
    assign p1       = (NUM_FINGERS > 1) ? finger_state[F1_BIT] : 1'b0;
    assign single   = p0 && !p1;
    assign y0_disp  = f0.y < display_max_y_reg;
    assign y1_disp  = f1.y < display_max_y_reg;
    assign y0_key   = f0.y > key_min_y_reg;
    assign key0     = zone_key(f0.x);

    // A lone finger 0 stays on screen once screen mode is set
    assign single_screen = (y0_disp && prior_mode_reg == MODE_NONE)
                        || prior_mode_reg == MODE_SCREEN;

    assign point0     = '{kind: EV_POINT, x: f0.x, y: f0.y, p: f0.p, w: f0.w, key: KEY_NONE};
    assign point1     = '{kind: EV_POINT, x: f1.x, y: f1.y, p: f1.p, w: f1.w, key: KEY_NONE};
    assign release_ev = '{kind: EV_RELEASE, x: '0, y: '0, p: '0, w: '0, key: held_key_reg};
    assign press_ev   = '{kind: EV_PRESS, x: '0, y: '0, p: '0, w: '0, key: key0};

    always_comb
    begin
        a_v             = 1'b0;
        a_ev            = point0;
        press           = 1'b0;
        prior_mode_next = MODE_SCREEN;
        if (!p0)
        begin
            a_v  = 1'b1;
            a_ev = release_ev;
        end
        else if (single)
        begin
            if (single_screen)
            begin
                a_v = y0_disp;
            end
            else if (y0_key)
            begin
                prior_mode_next = MODE_KEY;
                a_ev            = press_ev;
                if (key0 != KEY_NONE && !first_down_reg)
                begin
                    a_v   = 1'b1;
                    press = 1'b1;
                end
            end
            else
            begin
                // Touch between key strip and display: report as a point
                a_v = 1'b1;
            end
        end
        else
        begin
            a_v = y0_disp;
        end
        if (!p0 && !p1)
            prior_mode_next = MODE_NONE;
    end

    assign b_v = p1 && y1_disp;

    // Compact the two candidate events into a frame record
    always_comb
    begin
        push_frame.ev0  = a_v ? a_ev : point1;
        push_frame.ev1  = point1;
        push_frame.n_ev = abs_data ? (NEV_W'(a_v) + NEV_W'(b_v)) : '0;
    end

    assign in_ready  = !q_full;
    assign push      = in_valid && !q_full;
    assign accept    = push;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            display_max_y_reg <= DISPLAY_MAX_Y_RST;
            key_min_y_reg     <= KEY_MIN_Y_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_DISPLAY_MAX_Y: display_max_y_reg <= cfg_data;
                REG_KEY_MIN_Y:     key_min_y_reg     <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prior_mode_reg <= MODE_NONE;
            held_key_reg   <= KEY_NONE;
            first_down_reg <= 1'b0;
        end
        else if (accept && abs_data)
        begin
            prior_mode_reg <= prior_mode_next;
            first_down_reg <= p0;
            if (press)
                held_key_reg <= key0;
        end
    end

    // Frames without new data leave the touch state untouched
    a_no_data_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !abs_data) |=> ($stable(prior_mode_reg) && $stable(held_key_reg)
                                   && $stable(first_down_reg)))
        else $error("state changed on a frame without new data");

    a_held_key_range: assert property (@(posedge clk) disable iff (!rst_n)
        held_key_reg <= BTN_SEARCH)
        else $error("held key out of range");

endmodule

`default_nettype wire

FILE: design/trc_queue.sv
// Small FIFO of classified frame records between front end and sequencer.
// Depends on trc_pkg for the record type and depth constants.
`timescale 1ns / 1ps
`default_nettype none

module trc_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire trc_pkg::frame_t   push_frame,
    output logic                   full,
    input  wire logic              pop,
    output trc_pkg::frame_t        head,
    output logic                   head_valid
);
    import trc_pkg::*;

    frame_t              mem [QDEPTH];
    logic [QAW-1:0]      wr_ptr_reg;
    logic [QAW-1:0]      wr_ptr_next;
    logic [QAW-1:0]      rd_ptr_reg;
    logic [QAW-1:0]      rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                do_pop;

    assign full       = count_reg == QCNT_W'(QDEPTH);
    assign head_valid = count_reg != '0;
    assign head       = mem[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_frame;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("frame queue overflow");

endmodule

`default_nettype wire

FILE: design/trc_back.sv
// Back end: walks the head frame record and issues its events, then a frame end.
// Depends on trc_pkg; feeds the registered output channel of the top level.
`timescale 1ns / 1ps
`default_nettype none

module trc_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire trc_pkg::frame_t               head,
    input  wire logic                          head_valid,
    output logic                               pop,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [1:0]                         event_kind,
    output logic [trc_pkg::COORD_W-1:0]        pos_x,
    output logic [trc_pkg::COORD_W-1:0]        pos_y,
    output logic [trc_pkg::PRESS_W-1:0]        pressure,
    output logic [trc_pkg::WIDTH_W-1:0]        contact_width,
    output logic [trc_pkg::KEY_W-1:0]          key_code,
    output logic                               last
);
    import trc_pkg::*;

    logic             out_valid_reg;
    logic             out_valid_next;
    event_t           out_ev_reg;
    logic             out_last_reg;
    logic [NEV_W-1:0] step_reg;
    logic [NEV_W-1:0] step_next;
    logic             load;
    logic             at_end;
    event_t           cur_ev;
    event_t           end_ev;

    assign load   = !out_valid_reg || out_ready;
    assign at_end = step_reg == head.n_ev;
    assign end_ev = '{kind: EV_END, x: '0, y: '0, p: '0, w: '0, key: KEY_NONE};

    always_comb
    begin
        priority if (at_end)
            cur_ev = end_ev;
        else if (step_reg == '0)
            cur_ev = head.ev0;
        else
            cur_ev = head.ev1;
    end

    assign pop = load && head_valid && at_end;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        step_next      = step_reg;
        if (load)
        begin
            out_valid_next = head_valid;
            if (head_valid)
                step_next = at_end ? '0 : step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
        end
    end

    // Payload: load on every free slot, hold while stalled
    always_ff @(posedge clk)
    begin
        if (load && head_valid)
        begin
            out_ev_reg   <= cur_ev;
            out_last_reg <= at_end;
        end
    end

    assign out_valid     = out_valid_reg;
    assign event_kind    = out_ev_reg.kind;
    assign pos_x         = out_ev_reg.x;
    assign pos_y         = out_ev_reg.y;
    assign pressure      = out_ev_reg.p;
    assign contact_width = out_ev_reg.w;
    assign key_code      = out_ev_reg.key;
    assign last          = out_last_reg;

    a_step_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> step_reg <= head.n_ev)
        else $error("event step beyond frame record");

endmodule

`default_nettype wire

FILE: design/touch_report_classifier_top.sv
// Top level of the touch report classifier: front end, frame queue, sequencer.
// Depends on trc_pkg, trc_front, trc_queue and trc_back.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one raw two-finger frame per
//   transfer. Output channel (out_valid/out_ready) returns its events in
//   order: up to two touch-point / key-press / key-release events, then a
//   frame end with last high. Every frame yields one to three results.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   display_max_y (index 0) or key_min_y (index 1); cfg_ready is always high.
//   With the block idle, a frame's first result is registered in the frame
//   queue and then in the output register before it is shown. The front end
//   classifies a frame in its transfer cycle; the sequencer issues one result
//   per cycle while out_ready stays high, and the results of the next queued
//   frame follow a frame end directly. A two-entry frame queue sits between.
//   Reset clears mode, held key, finger-down flag and the queue, and loads
//   the configuration registers with their default limits.
//   When the receiver stalls, the output register holds; the queue keeps
//   taking frames until both entries are used, then in_ready drops.
`timescale 1ns / 1ps
`default_nettype none

module touch_report_classifier_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [trc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [trc_pkg::COORD_W-1:0]   cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [7:0]                    irq_status,
    input  wire logic [7:0]                    finger_state,
    input  wire logic [trc_pkg::RAW_W-1:0]     finger0_bytes,
    input  wire logic [trc_pkg::RAW_W-1:0]     finger1_bytes,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [1:0]                         event_kind,
    output logic [trc_pkg::COORD_W-1:0]        pos_x,
    output logic [trc_pkg::COORD_W-1:0]        pos_y,
    output logic [trc_pkg::PRESS_W-1:0]        pressure,
    output logic [trc_pkg::WIDTH_W-1:0]        contact_width,
    output logic [trc_pkg::KEY_W-1:0]          key_code,
    output logic                               last
);
    import trc_pkg::*;

    logic   q_full;
    logic   push;
    frame_t push_frame;
    logic   pop;
    frame_t head;
    logic   head_valid;

    trc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .irq_status    (irq_status),
        .finger_state  (finger_state),
        .finger0_bytes (finger0_bytes),
        .finger1_bytes (finger1_bytes),
        .q_full        (q_full),
        .push          (push),
        .push_frame    (push_frame)
    );

    trc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_frame (push_frame),
        .full       (q_full),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    trc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .head_valid    (head_valid),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .event_kind    (event_kind),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .pressure      (pressure),
        .contact_width (contact_width),
        .key_code      (key_code),
        .last          (last)
    );

endmodule

`default_nettype wire
